// ===== rtl/ascii_integer_parser_top_defines.svh =====
// ----------------------------------------------------------------------------
// ascii_integer_parser_top_defines
// Assertion macros used by the parser RTL. Each use sits inside a module
// that has clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef ASCII_INTEGER_PARSER_TOP_DEFINES_SVH
`define ASCII_INTEGER_PARSER_TOP_DEFINES_SVH

// same-cycle implication
`define AIP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/aip_pkg.sv =====
// ----------------------------------------------------------------------------
// aip_pkg
// Types and constants for the streaming ASCII integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

    localparam int MAX_COUNT_DEFAULT = 255;

    localparam int VALUE_W = 32;
    localparam int COUNT_OUT_W = 8;
    localparam int BASE_W = 5;

    localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;
    localparam logic [BASE_W-1:0] BASE_DEC = 5'd10;
    localparam logic [BASE_W-1:0] BASE_HEX = 5'd16;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF = 8'h66;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;
    localparam logic [7:0] CH_LX = 8'h78;
    localparam logic [7:0] CH_UX = 8'h58;

    typedef enum logic [4:0] {
        PH_SPACE  = 5'b00001,
        PH_BASE   = 5'b00010,
        PH_ZERO   = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       first_char;
    } char_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  parsed_value;
        logic [COUNT_OUT_W-1:0]     consumed_count;
    } result_item_t;

endpackage

// ===== rtl/ascii_integer_parser_top.sv =====
// ----------------------------------------------------------------------------
// ascii_integer_parser_top
// Streaming signed integer parser, one string byte per item.
// ----------------------------------------------------------------------------
//  channel | signals                          | item
//  char    | char_valid, char_stall, char_item| one byte, start-of-string flag
//  result  | result_valid, result_stall,      | value and consumed byte count
//          | result_item                      |
//  cfg     | cfg_valid, cfg_ready, cfg_data   | number_base
//
//  One item per cycle unless result_stall holds a pending result. A byte is
//  held in the input register, parsed against the state combinationally, and a
//  result lands in the output register.
//  Reset clears the parse state and sets number_base to 10.
//  result_stall holds the output register and then the input register.
// ----------------------------------------------------------------------------
`include "ascii_integer_parser_top_defines.svh"

module ascii_integer_parser_top #(
    parameter int MAX_COUNT = aip_pkg::MAX_COUNT_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        char_valid,
    output logic                        char_stall,
    input  aip_pkg::char_item_t         char_item,
    output logic                        result_valid,
    input  logic                        result_stall,
    output aip_pkg::result_item_t       result_item,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [aip_pkg::BASE_W-1:0]  cfg_data
);
    import aip_pkg::*;

    localparam int CW = $clog2(MAX_COUNT + 1);
    localparam int EW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v < CW'(MAX_COUNT)) ? CW'(v + CW'(1)) : v;
    endfunction

    logic                   char_valid_reg;
    char_item_t             char_item_reg;
    logic                   result_valid_reg;
    logic                   result_valid_next;
    result_item_t           result_item_reg;
    logic [BASE_W-1:0]      number_base_reg;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [VALUE_W-1:0]     acc_reg;
    logic [VALUE_W-1:0]     acc_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic [BASE_W-1:0]      wbase_reg;
    logic [BASE_W-1:0]      wbase_next;
    logic [CW-1:0]          cnt_reg;
    logic [CW-1:0]          cnt_next;

    logic                   advance;
    logic                   emit;
    logic                   run_digit;
    logic [7:0]             c;
    phase_t                 ph_cur;
    logic [VALUE_W-1:0]     acc_cur;
    logic                   is_digit;
    logic [BASE_W-1:0]      dval;
    logic [VALUE_W-1:0]     value;
    logic [EW-1:0]          cnt_wide;

    assign advance    = char_valid_reg && (!result_valid_reg || !result_stall);
    assign char_stall = char_valid_reg && !advance;
    assign cfg_ready  = 1'b1;

    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

    assign c = char_item_reg.char_code;

    always_comb
    begin
        is_digit = 1'b0;
        dval     = '0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            is_digit = 1'b1;
            dval     = BASE_W'(c - CH_ZERO);
        end
        else if (c >= CH_LA && c <= CH_LF)
        begin
            is_digit = 1'b1;
            dval     = BASE_W'(c - CH_LA + 8'd10);
        end
        else if (c >= CH_UA && c <= CH_UF)
        begin
            is_digit = 1'b1;
            dval     = BASE_W'(c - CH_UA + 8'd10);
        end
    end

    always_comb
    begin
        ph_cur     = char_item_reg.first_char ? PH_SPACE : phase_reg;
        acc_cur    = char_item_reg.first_char ? '0 : acc_reg;
        neg_next   = char_item_reg.first_char ? 1'b0 : neg_reg;
        wbase_next = char_item_reg.first_char ? '0 : wbase_reg;
        cnt_next   = char_item_reg.first_char ? '0 : cnt_reg;
        phase_next = ph_cur;
        acc_next   = acc_cur;
        run_digit  = 1'b0;
        emit       = 1'b0;

        unique case (ph_cur)
            PH_SPACE, PH_BASE:
            begin
                if (ph_cur == PH_SPACE && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)))
                begin
                    cnt_next = sat_inc(cnt_next);
                end
                else if (ph_cur == PH_SPACE && (c == CH_PLUS || c == CH_MINUS))
                begin
                    neg_next   = (c == CH_MINUS);
                    cnt_next   = sat_inc(cnt_next);
                    phase_next = PH_BASE;
                end
                else if (number_base_reg == '0 && c == CH_ZERO)
                begin
                    phase_next = PH_ZERO;
                end
                else
                begin
                    wbase_next = (number_base_reg == '0) ? BASE_DEC : number_base_reg;
                    phase_next = PH_DIGITS;
                    run_digit  = 1'b1;
                end
            end
            PH_ZERO:
            begin
                phase_next = PH_DIGITS;
                if (c == CH_LX || c == CH_UX)
                begin
                    wbase_next = BASE_HEX;
                    cnt_next   = sat_inc(sat_inc(cnt_next));
                end
                else
                begin
                    wbase_next = BASE_DEC;
                    cnt_next   = sat_inc(cnt_next);
                    run_digit  = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                run_digit = 1'b1;
            end
            default:
            begin
                phase_next = ph_cur;
            end
        endcase

        // digit step on the working base chosen above
        if (run_digit)
        begin
            if (is_digit && dval < wbase_next)
            begin
                acc_next = VALUE_W'(acc_cur * VALUE_W'(wbase_next)) + VALUE_W'(dval);
                cnt_next = sat_inc(cnt_next);
            end
            else
            begin
                emit       = 1'b1;
                phase_next = PH_DONE;
            end
        end

        value    = neg_next ? VALUE_W'(0 - acc_cur) : acc_cur;
        cnt_wide = EW'(cnt_next);
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (advance && emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            number_base_reg  <= BASE_RESET;
            phase_reg        <= PH_SPACE;
            acc_reg          <= '0;
            neg_reg          <= 1'b0;
            wbase_reg        <= '0;
            cnt_reg          <= '0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (!char_stall)
            begin
                char_valid_reg <= char_valid;
            end
            if (cfg_valid && cfg_ready)
            begin
                number_base_reg <= cfg_data;
            end
            if (advance)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                wbase_reg <= wbase_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            char_item_reg <= char_item;
        end
        if (advance && emit)
        begin
            result_item_reg.parsed_value   <= signed'(value);
            result_item_reg.consumed_count <= cnt_wide[COUNT_OUT_W-1:0];
        end
    end

    `AIP_ASSERT_NEXT(a_emit_done, (advance && emit), (phase_reg == PH_DONE),
        "result produced but parser not finished")
    `AIP_ASSERT_NOW(a_cnt_sat, 1'b1, (cnt_reg <= CW'(MAX_COUNT)),
        "byte count above saturation limit")
    `AIP_ASSERT_NOW(a_acc_clear,
        (phase_reg == PH_SPACE || phase_reg == PH_BASE || phase_reg == PH_ZERO),
        (acc_reg == '0), "accumulator nonzero before digits")
    `AIP_ASSERT_NOW(a_sign_space, (phase_reg == PH_SPACE), (!neg_reg),
        "sign flag set during whitespace")

endmodule
